[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants for the cartridge bank mapper with cycle interrupt.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_PRG   = 2'd2;
  localparam logic [1:0] OP_CHR   = 2'd3;

  localparam logic [1:0] KIND_PRG_ROM = 2'd0;
  localparam logic [1:0] KIND_PRG_RAM = 2'd1;
  localparam logic [1:0] KIND_CHR_ROM = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [15:0] ADDR_PRG0     = 16'h8000;
  localparam logic [15:0] ADDR_PRG1     = 16'hA000;
  localparam logic [15:0] ADDR_PRG2     = 16'hC000;
  localparam logic [15:0] ADDR_MIRROR   = 16'h9000;
  localparam logic [15:0] ADDR_IRQ_EN   = 16'h9003;
  localparam logic [15:0] ADDR_IRQ_LOAD = 16'h9004;
  localparam logic [15:0] ADDR_RELOAD_H = 16'h9005;
  localparam logic [15:0] ADDR_RELOAD_L = 16'h9006;
  localparam logic [12:0] ADDR_CHR_BASE = 13'h1600;  // $B000 >> 3

  localparam logic [7:0] FIXED_LAST_BANK = 8'hFF;
  localparam logic [7:0] PRG_BANK2_RESET = 8'hFE;
  localparam int         MIRROR_H_BIT    = 6;
  localparam int         ENABLE_BIT      = 7;
  localparam int         NUM_PRG         = 3;
  localparam int         NUM_CHR         = 8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [20:0] mapped_address;
    logic [1:0]  mapped_kind;
    logic        irq_asserted;
    logic        mirror_horizontal;
  } out_word_t;

endpackage

[rtl/cartridge_bank_mapper_irq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_core
// Bank mapper with PRG/CHR bank registers and a CPU-cycle down-counter IRQ.
//
//   channel | ports                           | moves
//   in      | in_valid, in_stall, in_word     | op, address, data
//   out     | out_valid, out_stall, out_word  | mapped address, kind, irq, mirror
//
// Each word passes through the input register and then the result register;
// one word per cycle is sustained while out_stall is low.
// State updates and the result are formed in the single pass between them.
// A stalled result holds the input register; reset presets banks, clears control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartridge_bank_mapper_irq_core
  import cbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  logic [7:0]  prg_bank_r [NUM_PRG];
  logic [7:0]  chr_bank_r [NUM_CHR];
  logic [7:0]  mirror_r, mirror_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic [15:0] irq_count_r, irq_count_nxt;
  logic [15:0] irq_reload_r, irq_reload_nxt;
  logic        irq_line_r, irq_line_nxt;

  logic        advance;
  logic        fire;
  logic [15:0] count_dec;
  logic [1:0]  prg_slot;
  logic [7:0]  prg_sel;
  logic [20:0] mapped;
  logic [1:0]  kind;
  out_word_t   out_nxt;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign count_dec = irq_count_r - 16'd1;

  // control and counter next state
  always_comb begin
    mirror_nxt     = mirror_r;
    irq_en_nxt     = irq_en_r;
    irq_count_nxt  = irq_count_r;
    irq_reload_nxt = irq_reload_r;
    irq_line_nxt   = irq_line_r;
    if (s1_word_r.opcode == OP_WRITE) begin
      if (s1_word_r.address == ADDR_MIRROR) begin
        mirror_nxt = s1_word_r.data;
      end else if (s1_word_r.address == ADDR_IRQ_EN) begin
        irq_en_nxt   = s1_word_r.data[ENABLE_BIT];
        irq_line_nxt = 1'b0;
      end else if (s1_word_r.address == ADDR_IRQ_LOAD) begin
        irq_count_nxt = irq_reload_r;
        irq_line_nxt  = 1'b0;
      end else if (s1_word_r.address == ADDR_RELOAD_H) begin
        irq_reload_nxt = {s1_word_r.data, irq_reload_r[7:0]};
      end else if (s1_word_r.address == ADDR_RELOAD_L) begin
        irq_reload_nxt = {irq_reload_r[15:8], s1_word_r.data};
      end
    end else if (s1_word_r.opcode == OP_TICK) begin
      if (irq_en_r) begin
        irq_count_nxt = count_dec;
        if (count_dec == 16'd0) begin
          irq_line_nxt = 1'b1;
          irq_en_nxt   = 1'b0;
        end
      end
    end
  end

  // address translation
  assign prg_slot = s1_word_r.address[14:13];
  always_comb begin
    case (prg_slot)
      2'd0:    prg_sel = prg_bank_r[0];
      2'd1:    prg_sel = prg_bank_r[1];
      2'd2:    prg_sel = prg_bank_r[2];
      default: prg_sel = FIXED_LAST_BANK;
    endcase
  end

  always_comb begin
    mapped = 21'd0;
    kind   = KIND_NONE;
    case (s1_word_r.opcode)
      OP_PRG: begin
        if (s1_word_r.address[15]) begin
          mapped = {prg_sel, s1_word_r.address[12:0]};
          kind   = KIND_PRG_ROM;
        end else if (s1_word_r.address[14:13] == 2'b11) begin
          mapped = {8'd0, s1_word_r.address[12:0]};
          kind   = KIND_PRG_RAM;
        end
      end
      OP_CHR: begin
        if (s1_word_r.address[15:13] == 3'd0) begin
          mapped = {3'd0, chr_bank_r[s1_word_r.address[12:10]], s1_word_r.address[9:0]};
          kind   = KIND_CHR_ROM;
        end
      end
      default: begin
        mapped = 21'd0;
        kind   = KIND_NONE;
      end
    endcase
  end

  always_comb begin
    out_nxt.mapped_address    = mapped;
    out_nxt.mapped_kind       = kind;
    out_nxt.irq_asserted      = irq_line_nxt;
    out_nxt.mirror_horizontal = mirror_nxt[MIRROR_H_BIT];
  end

  // handshake stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_word_r <= in_word;
    end
    if (fire) begin
      out_word_r <= out_nxt;
    end
  end

  // mapper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r[0] <= 8'd0;
      prg_bank_r[1] <= 8'd1;
      prg_bank_r[2] <= PRG_BANK2_RESET;
      for (int i = 0; i < NUM_CHR; i++) begin
        chr_bank_r[i] <= 8'(i);
      end
      mirror_r     <= 8'd0;
      irq_en_r     <= 1'b0;
      irq_count_r  <= 16'd0;
      irq_reload_r <= 16'd0;
      irq_line_r   <= 1'b0;
    end else if (fire) begin
      mirror_r     <= mirror_nxt;
      irq_en_r     <= irq_en_nxt;
      irq_count_r  <= irq_count_nxt;
      irq_reload_r <= irq_reload_nxt;
      irq_line_r   <= irq_line_nxt;
      if (s1_word_r.opcode == OP_WRITE) begin
        if (s1_word_r.address == ADDR_PRG0) begin
          prg_bank_r[0] <= s1_word_r.data;
        end
        if (s1_word_r.address == ADDR_PRG1) begin
          prg_bank_r[1] <= s1_word_r.data;
        end
        if (s1_word_r.address == ADDR_PRG2) begin
          prg_bank_r[2] <= s1_word_r.data;
        end
        if (s1_word_r.address[15:3] == ADDR_CHR_BASE) begin
          chr_bank_r[s1_word_r.address[2:0]] <= s1_word_r.data;
        end
      end
    end
  end

  `CBM_ASSERT(a_en_line_excl, clk, rst_n, !(irq_en_r && irq_line_r), "irq enable and line both set")
  `CBM_ASSERT(a_line_rise_tick, clk, rst_n, $rose(irq_line_r) |-> $past(fire && (s1_word_r.opcode == OP_TICK)), "irq line rose without a tick")
  `CBM_ASSERT(a_hold_on_stall, clk, rst_n, (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r, "input register lost a word under stall")
  `CBM_ASSERT_ALWAYS(a_chr_range, clk, (out_valid_r && out_word_r.mapped_kind == KIND_CHR_ROM) |-> (out_word_r.mapped_address[20:18] == 3'd0), "chr address out of range")

endmodule
